FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the six face calibrator
// immediate-style concurrent checks sampled on the rising clock edge
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define A6_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define A6_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/a6cal_pkg.sv
// ---------------------------------------------------------------------------
// a6cal_pkg
// shared widths, register codes and control structs of the calibrator
// ---------------------------------------------------------------------------
`default_nettype none

package a6cal_pkg;

  localparam int ACC_W     = 16;  // raw sample width
  localparam int CFG_W     = 15;  // configuration register width
  localparam int CFG_IDX_W = 1;   // register index width
  localparam int CNT_W     = 8;   // per phase sample count
  localparam int AXIS_W    = 2;
  localparam int SUM_W     = 24;  // per axis accumulator
  localparam int NUM_W     = 25;  // sum or difference of two accumulators
  localparam int Q_W       = 24;  // q.8 result width

  localparam logic [CFG_W-1:0] ONE_G_RESET = 15'd8192;
  localparam logic [CFG_W-1:0] TOL_RESET   = 15'd819;

  localparam logic [Q_W-1:0] Q_MAX = 24'h7FFFFF;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic SIDE_POS = 1'b0;
  localparam logic SIDE_NEG = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ONE_G = 1'b0,
    REG_TOL   = 1'b1
  } cfg_reg_t;

  typedef logic signed [ACC_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic signed [Q_W-1:0]   q8_t;

  // collect stage strobes
  typedef struct packed {
    logic load;  // capture input item into the input register
    logic step;  // input register item moves on, state updates
  } collect_ctl_t;

  // enables of the scaling stages
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

`default_nettype wire

FILE: hw/rtl/a6cal_intf.sv
// ---------------------------------------------------------------------------
// a6cal channel interfaces
// valid/ready channels for sample items and result items
// ---------------------------------------------------------------------------
`default_nettype none

interface a6cal_sample_if;
  logic                    valid;
  logic                    ready;
  logic signed [15:0]      accel_x;
  logic signed [15:0]      accel_y;
  logic signed [15:0]      accel_z;
  logic                    restart;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  output restart, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  input restart, output ready);
endinterface

interface a6cal_result_if;
  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic [1:0]              phase_axis;
  logic                    phase_side;
  logic [7:0]              collected;
  logic                    done_res;
  logic signed [23:0]      bias_x;
  logic signed [23:0]      bias_y;
  logic signed [23:0]      bias_z;
  logic signed [23:0]      gain_x;
  logic signed [23:0]      gain_y;
  logic signed [23:0]      gain_z;

  modport source (output valid, output accepted, output phase_axis, output phase_side,
                  output collected, output done_res, output bias_x, output bias_y,
                  output bias_z, output gain_x, output gain_y, output gain_z,
                  input ready);
  modport sink   (input valid, input accepted, input phase_axis, input phase_side,
                  input collected, input done_res, input bias_x, input bias_y,
                  input bias_z, input gain_x, input gain_y, input gain_z,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/a6cal_collect.sv
// ---------------------------------------------------------------------------
// a6cal_collect
// input register, phase state and accumulators, tolerance check
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module a6cal_collect #(
  parameter int SAMPLES = 150
) (
  input  logic                                clk,
  input  logic                                rst,
  input  a6cal_pkg::collect_ctl_t             ctl,
  input  logic [a6cal_pkg::CFG_W-1:0]         one_g,
  input  logic [a6cal_pkg::CFG_W-1:0]         tol,
  input  a6cal_pkg::sample_t                  accel_x,
  input  a6cal_pkg::sample_t                  accel_y,
  input  a6cal_pkg::sample_t                  accel_z,
  input  logic                                restart,
  output logic                                accepted,
  output logic [a6cal_pkg::AXIS_W-1:0]        phase_axis,
  output logic                                phase_side,
  output logic [a6cal_pkg::CNT_W-1:0]         collected,
  output logic                                done_res,
  output a6cal_pkg::sum_t                     pos_sum [3],
  output a6cal_pkg::sum_t                     neg_sum [3]
);
  import a6cal_pkg::*;

  // input register
  sample_t in_x, in_y, in_z;
  logic    in_restart;

  // phase state
  logic [AXIS_W-1:0] cur_axis;
  logic              cur_side;
  logic [CNT_W-1:0]  phase_count;
  sum_t              pos_acc [3];
  sum_t              neg_acc [3];

  logic [AXIS_W-1:0] axis_c, ax, axis_next;
  logic              side_c, side_next;
  logic [CNT_W-1:0]  cnt_c, cnt_inc, cnt_next;
  sum_t              pos_c [3];
  sum_t              neg_c [3];
  sum_t              pos_next [3];
  sum_t              neg_next [3];
  sample_t           v;
  logic signed [17:0] target, diff, mag;
  logic              acc, phase_end, done;

  always_comb begin
    axis_c = in_restart ? AXIS_X : cur_axis;
    side_c = in_restart ? SIDE_POS : cur_side;
    cnt_c  = in_restart ? '0 : phase_count;
    for (int i = 0; i < 3; i++) begin
      pos_c[i] = in_restart ? '0 : pos_acc[i];
      neg_c[i] = in_restart ? '0 : neg_acc[i];
    end

    ax = (axis_c > AXIS_Z) ? AXIS_Z : axis_c;
    unique case (ax)
      AXIS_X:  v = in_x;
      AXIS_Y:  v = in_y;
      default: v = in_z;
    endcase

    // distance from the target of the current side
    target = (side_c == SIDE_NEG) ? -$signed({3'b000, one_g}) : $signed({3'b000, one_g});
    diff   = 18'(v) - target;
    mag    = diff[17] ? -diff : diff;
    acc    = $unsigned(mag) < {3'b000, tol};

    cnt_inc   = cnt_c + CNT_W'(1);
    phase_end = acc && (cnt_inc >= CNT_W'(SAMPLES));

    for (int i = 0; i < 3; i++) begin
      pos_next[i] = pos_c[i] +
        ((acc && side_c == SIDE_POS && ax == AXIS_W'(i)) ? SUM_W'(v) : '0);
      neg_next[i] = neg_c[i] +
        ((acc && side_c == SIDE_NEG && ax == AXIS_W'(i)) ? SUM_W'(v) : '0);
    end

    axis_next = axis_c;
    side_next = side_c;
    cnt_next  = cnt_c;
    done      = 1'b0;
    if (acc) begin
      cnt_next = cnt_inc;
      if (phase_end) begin
        cnt_next = '0;
        if (side_c == SIDE_POS) begin
          side_next = SIDE_NEG;
        end else begin
          side_next = SIDE_POS;
          if (ax == AXIS_Z) begin
            done = 1'b1;
          end else begin
            axis_next = ax + AXIS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      in_x       <= accel_x;
      in_y       <= accel_y;
      in_z       <= accel_z;
      in_restart <= restart;
    end
    if (ctl.step) begin
      accepted   <= acc;
      phase_axis <= done ? AXIS_X : axis_next;
      phase_side <= done ? SIDE_POS : side_next;
      collected  <= done ? '0 : cnt_next;
      done_res   <= done;
      pos_sum    <= pos_next;
      neg_sum    <= neg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_axis    <= AXIS_X;
      cur_side    <= SIDE_POS;
      phase_count <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_acc[i] <= '0;
        neg_acc[i] <= '0;
      end
    end else if (ctl.step) begin
      cur_axis    <= done ? AXIS_X : axis_next;
      cur_side    <= done ? SIDE_POS : side_next;
      phase_count <= done ? '0 : cnt_next;
      for (int i = 0; i < 3; i++) begin
        pos_acc[i] <= done ? '0 : pos_next[i];
        neg_acc[i] <= done ? '0 : neg_next[i];
      end
    end
  end

  `A6_ASSERT_ALWAYS(a_axis_range, clk, rst, cur_axis <= AXIS_Z, "axis state out of range")
  `A6_ASSERT_ALWAYS(a_count_range, clk, rst, phase_count < CNT_W'(SAMPLES), "phase count overrun")

endmodule

`default_nettype wire

FILE: hw/rtl/a6cal_qmean.sv
// ---------------------------------------------------------------------------
// a6cal_qmean
// one lane of num * 256 / (2 * SAMPLES), truncated toward zero, saturated
// ---------------------------------------------------------------------------
`default_nettype none

module a6cal_qmean #(
  parameter int SAMPLES = 150
) (
  input  logic                 clk,
  input  a6cal_pkg::stage_en_t en,
  input  a6cal_pkg::num_t      num,
  input  logic                 done,
  output a6cal_pkg::q8_t       q
);
  import a6cal_pkg::*;

  // rounded-up reciprocal, exact for every magnitude the sums can reach
  localparam int          D   = 2 * SAMPLES;
  localparam int          DB  = $clog2(D);
  localparam int          K   = Q_W + 2 * DB;
  localparam logic [63:0] M   = ((64'd1 << K) + 64'(D) - 64'd1) / 64'(D);
  localparam int          MW  = K - DB + 2;
  localparam int          MLW = (MW + 1) / 2;
  localparam int          MHW = MW - MLW;
  localparam int          XW  = NUM_W;
  localparam int          PW  = XW + MW;
  localparam logic [MLW-1:0] M_LO = M[MLW-1:0];
  localparam logic [MHW-1:0] M_HI = M[MW-1:MLW];

  logic [XW-1:0]     x3;
  logic              n3, n4;
  logic [XW+MLW-1:0] pl4;
  logic [XW+MHW-1:0] ph4;
  logic [PW-1:0]     prod;
  logic [Q_W-1:0]    qmag, qres;

  always_comb begin
    prod = {ph4, {MLW{1'b0}}} + PW'(pl4);
    qmag = prod[K-8 +: Q_W];
    if (n4) begin
      qres = ~qmag + Q_W'(1);
    end else begin
      qres = qmag[Q_W-1] ? Q_MAX : qmag;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      // magnitude only on completion, else the lane yields zero
      x3 <= done ? (num[NUM_W-1] ? XW'(-num) : XW'(num)) : '0;
      n3 <= done & num[NUM_W-1];
    end
    if (en.s4) begin
      pl4 <= x3 * M_LO;
      ph4 <= x3 * M_HI;
      n4  <= n3;
    end
    if (en.s5) begin
      q <= $signed(qres);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/accel_six_face_calibrator_core.sv
// path: a sample item passes the input, collect, abs, product and output registers
// throughput: one item per cycle unless the result side stalls; phase state and sums
//   update in the collect stage, so back-to-back samples see each other's effect
// reset: synchronous, clears phase, sums and pipeline valids; one g and tolerance
//   return to 8192 and 819 counts
// ---------------------------------------------------------------------------
// accel_six_face_calibrator_core
// six position accelerometer calibration: tolerance-gated collection per axis
// and side, then per axis bias and half span in q.8 counts
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module accel_six_face_calibrator_core #(
  parameter int SAMPLES = 150
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [a6cal_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [a6cal_pkg::CFG_W-1:0]       wr_data,
  a6cal_sample_if.sink                      sample,
  a6cal_result_if.source                    result
);
  import a6cal_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] one_g, tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_g <= ONE_G_RESET;
      tol   <= TOL_RESET;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_ONE_G: one_g <= wr_data;
        REG_TOL:   tol   <= wr_data;
      endcase
    end
  end

  // pipeline occupancy: s1 input reg, s2 collect result, s3 abs, s4 partial
  // products, s5 output reg; a stage loads when empty or when it drains
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || result.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign sample.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= sample.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  collect_ctl_t ctl;
  stage_en_t    sen;

  assign ctl.load = en1;
  assign ctl.step = en2 && v1;
  assign sen.s3   = en3;
  assign sen.s4   = en4;
  assign sen.s5   = en5;

  // collect stage: tolerance check, sums, phase sequencing
  logic              acc2, side2, done2;
  logic [AXIS_W-1:0] axis2;
  logic [CNT_W-1:0]  cnt2;
  sum_t              pos2 [3];
  sum_t              neg2 [3];

  a6cal_collect #(.SAMPLES(SAMPLES)) u_collect (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .one_g      (one_g),
    .tol        (tol),
    .accel_x    (sample.accel_x),
    .accel_y    (sample.accel_y),
    .accel_z    (sample.accel_z),
    .restart    (sample.restart),
    .accepted   (acc2),
    .phase_axis (axis2),
    .phase_side (side2),
    .collected  (cnt2),
    .done_res   (done2),
    .pos_sum    (pos2),
    .neg_sum    (neg2)
  );

  // lanes 0..2 give bias from pos + neg, lanes 3..5 half span from pos - neg
  num_t num [6];
  q8_t  qv  [6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i]     = NUM_W'(pos2[i]) + NUM_W'(neg2[i]);
      num[i + 3] = NUM_W'(pos2[i]) - NUM_W'(neg2[i]);
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_lane
    a6cal_qmean #(.SAMPLES(SAMPLES)) u_qmean (
      .clk  (clk),
      .en   (sen),
      .num  (num[g]),
      .done (done2),
      .q    (qv[g])
    );
  end

  // status fields ride alongside the scaling lanes
  logic              acc3, side3, done3, acc4, side4, done4, acc5, side5, done5;
  logic [AXIS_W-1:0] axis3, axis4, axis5;
  logic [CNT_W-1:0]  cnt3, cnt4, cnt5;

  always_ff @(posedge clk) begin
    if (en3) begin
      acc3  <= acc2;
      axis3 <= axis2;
      side3 <= side2;
      cnt3  <= cnt2;
      done3 <= done2;
    end
    if (en4) begin
      acc4  <= acc3;
      axis4 <= axis3;
      side4 <= side3;
      cnt4  <= cnt3;
      done4 <= done3;
    end
    if (en5) begin
      acc5  <= acc4;
      axis5 <= axis4;
      side5 <= side4;
      cnt5  <= cnt4;
      done5 <= done4;
    end
  end

  assign result.valid      = v5;
  assign result.accepted   = acc5;
  assign result.phase_axis = axis5;
  assign result.phase_side = side5;
  assign result.collected  = cnt5;
  assign result.done_res   = done5;
  assign result.bias_x     = qv[0];
  assign result.bias_y     = qv[1];
  assign result.bias_z     = qv[2];
  assign result.gain_x     = qv[3];
  assign result.gain_y     = qv[4];
  assign result.gain_z     = qv[5];

  // output stage views for the checks below
  logic phase_clear5, cal_zero5;

  assign phase_clear5 = (axis5 == AXIS_X) && (side5 == SIDE_POS) && (cnt5 == '0);
  assign cal_zero5    = (qv[0] == '0) && (qv[1] == '0) && (qv[2] == '0) &&
                        (qv[3] == '0) && (qv[4] == '0) && (qv[5] == '0);

  // completion item reports the cleared phase
  `A6_ASSERT_IMPLIES(a_done_cleared, clk, rst, v5 && done5, phase_clear5, "done item with live phase")
  // calibration values only on completion
  `A6_ASSERT_IMPLIES(a_idle_zero, clk, rst, v5 && !done5, cal_zero5, "calibration without done")
  // completion needs an accepted sample
  `A6_ASSERT_IMPLIES(a_done_accepted, clk, rst, v5 && done5, acc5, "done without accepted sample")

endmodule

`default_nettype wire

FILE: test/accel_six_face_calibrator_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// accel_six_face_calibrator_core_test
// self-checking bench for the six face accelerometer calibrator: sample items
// go in through a queue-fed driver, every result item is checked against an
// in-bench calibration predictor while both sides idle and stall at random
// ---------------------------------------------------------------------------
`default_nettype none

module accel_six_face_calibrator_core_test;

  import a6cal_pkg::*;

  localparam int     SAMPLES_PER_FACE = 150;
  localparam int     IDLE_PCT         = 28;       // chance of a gap or stall per cycle
  localparam int     LONG_HOLD        = 120;      // one long result-side stall
  localparam int     HOLD_AT_CYCLE    = 300;
  localparam int     QUIET_FROM       = 600;      // stretch with no gaps on either side
  localparam int     QUIET_TO         = 900;
  localparam int     CYCLE_LIMIT      = 20000;
  localparam int     NUM_SETTINGS     = 7;
  localparam longint Q8_HI            = 64'sd8388607;
  localparam longint Q8_LO            = -64'sd8388608;

  // one sample item as the sender offers it
  typedef struct {
    sample_t accel_x;
    sample_t accel_y;
    sample_t accel_z;
    logic    restart;
  } sample_item_t;

  // collection progress and per axis sums
  typedef struct {
    logic [AXIS_W-1:0] axis;
    logic              side;
    logic [CNT_W-1:0]  count;
    sum_t              pos_sum[3];
    sum_t              neg_sum[3];
  } calib_state_t;

  // one result item
  typedef struct {
    logic              accepted;
    logic [AXIS_W-1:0] phase_axis;
    logic              phase_side;
    logic [CNT_W-1:0]  collected;
    logic              done_res;
    q8_t               bias[3];
    q8_t               gain[3];
  } calib_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0]   wr_data = '0;

  a6cal_sample_if sample_ch ();
  a6cal_result_if result_ch ();

  accel_six_face_calibrator_core #(
    .SAMPLES(SAMPLES_PER_FACE)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .sample  (sample_ch),
    .result  (result_ch)
  );

  // register values as the block should hold them
  logic [CFG_W-1:0] cur_one_g = ONE_G_RESET;
  logic [CFG_W-1:0] cur_tol   = TOL_RESET;

  // plan_state runs ahead with the stimulus, checked_state follows accepted items
  calib_state_t     plan_state;
  calib_state_t     checked_state;

  sample_item_t     samples_to_send[$];
  calib_result_t    results_due[$];
  calib_result_t    sample_outcome;
  calib_result_t    due;

  int               cycle_cnt = 0;
  int               hold_left = 0;
  logic             failed = 1'b0;
  logic             quiet_stretch;

  assign quiet_stretch = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // predictor
  // -------------------------------------------------------------------------

  function automatic void clear_calib(inout calib_state_t st);
    st.axis  = AXIS_X;
    st.side  = SIDE_POS;
    st.count = '0;
    for (int i = 0; i < 3; i++) begin
      st.pos_sum[i] = '0;
      st.neg_sum[i] = '0;
    end
  endfunction

  // (num * 256) / (2 * samples), truncated toward zero, saturated to q.8 range
  function automatic q8_t half_mean_q8(input longint num);
    longint r;
    r = (num * 256) / (2 * SAMPLES_PER_FACE);
    if (r > Q8_HI) r = Q8_HI;
    if (r < Q8_LO) r = Q8_LO;
    return q8_t'(r);
  endfunction

  function automatic calib_result_t calib_step(inout calib_state_t st,
                                               input sample_item_t it);
    calib_result_t r;
    int            v;
    int            target;
    int            distance;
    int            ax;
    logic          hit;
    logic          finished;
    if (it.restart) clear_calib(st);
    ax = (st.axis > AXIS_Z) ? 2 : int'(st.axis);
    case (ax)
      0:       v = int'(it.accel_x);
      1:       v = int'(it.accel_y);
      default: v = int'(it.accel_z);
    endcase
    // target is plus one g on the positive side, minus one g on the negative side
    target = (st.side == SIDE_NEG) ? -int'(cur_one_g) : int'(cur_one_g);
    distance = v - target;
    if (distance < 0) distance = -distance;
    hit = (distance < int'(cur_tol));
    finished = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r.bias[i] = '0;
      r.gain[i] = '0;
    end
    if (hit) begin
      if (st.side == SIDE_NEG) st.neg_sum[ax] = st.neg_sum[ax] + sum_t'(v);
      else st.pos_sum[ax] = st.pos_sum[ax] + sum_t'(v);
      st.count = st.count + 1'b1;
      if (st.count >= SAMPLES_PER_FACE) begin
        st.count = '0;
        if (st.side == SIDE_POS) begin
          st.side = SIDE_NEG;
        end else begin
          st.side = SIDE_POS;
          if (ax >= 2) finished = 1'b1;
          else st.axis = AXIS_W'(ax + 1);
        end
      end
    end
    if (finished) begin
      for (int i = 0; i < 3; i++) begin
        r.bias[i] = half_mean_q8(longint'(st.pos_sum[i]) + longint'(st.neg_sum[i]));
        r.gain[i] = half_mean_q8(longint'(st.pos_sum[i]) - longint'(st.neg_sum[i]));
      end
      clear_calib(st);
    end
    r.accepted   = hit;
    r.phase_axis = st.axis;
    r.phase_side = st.side;
    r.collected  = st.count;
    r.done_res   = finished;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // sample driver: offers the head of the queue, predicts on acceptance
  // -------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        sample_outcome = calib_step(checked_state, samples_to_send[0]);
        results_due.push_back(sample_outcome);
        void'(samples_to_send.pop_front());
      end
      // an item on offer stays until taken; otherwise maybe insert a gap
      if (!(sample_ch.valid && !sample_ch.ready)) begin
        if (samples_to_send.size() != 0 &&
            (quiet_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
          sample_ch.valid   <= 1'b1;
          sample_ch.accel_x <= samples_to_send[0].accel_x;
          sample_ch.accel_y <= samples_to_send[0].accel_y;
          sample_ch.accel_z <= samples_to_send[0].accel_z;
          sample_ch.restart <= samples_to_send[0].restart;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // result side: random stalls, one long hold to back the block up
  // -------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (cycle_cnt == HOLD_AT_CYCLE) begin
      result_ch.ready <= 1'b0;
      hold_left       <= LONG_HOLD;
    end else begin
      result_ch.ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string field, input longint want, input longint seen);
    if (want != seen) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, seen);
      failed = 1'b1;
    end
  endtask

  // result monitor: each accepted result item against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (results_due.size() == 0) begin
        $error("result item arrived with no prediction pending");
        failed = 1'b1;
      end else begin
        due = results_due.pop_front();
        check_field("accepted",   due.accepted,   result_ch.accepted);
        check_field("phase_axis", due.phase_axis, result_ch.phase_axis);
        check_field("phase_side", due.phase_side, result_ch.phase_side);
        check_field("collected",  due.collected,  result_ch.collected);
        check_field("done_res",   due.done_res,   result_ch.done_res);
        check_field("bias_x", longint'(due.bias[0]), longint'(result_ch.bias_x));
        check_field("bias_y", longint'(due.bias[1]), longint'(result_ch.bias_y));
        check_field("bias_z", longint'(due.bias[2]), longint'(result_ch.bias_z));
        check_field("gain_x", longint'(due.gain[0]), longint'(result_ch.gain_x));
        check_field("gain_y", longint'(due.gain[1]), longint'(result_ch.gain_y));
        check_field("gain_z", longint'(due.gain[2]), longint'(result_ch.gain_z));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("accel_six_face_calibrator_core regression: fail");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------

  // queue one item and advance the planning copy so the generator knows the phase
  task automatic queue_sample(input int x, input int y, input int z, input logic rs);
    sample_item_t  it;
    it.accel_x = sample_t'(x);
    it.accel_y = sample_t'(y);
    it.accel_z = sample_t'(z);
    it.restart = rs;
    samples_to_send.push_back(it);
    void'(calib_step(plan_state, it));
  endtask

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // mostly in-tolerance samples on the phase axis, else edge, opposite face or noise
  task automatic queue_random_sample();
    int vals[3];
    int ax;
    int tgt;
    int lo;
    int hi;
    int kind;
    int tol;
    for (int i = 0; i < 3; i++) vals[i] = int'($urandom_range(0, 65535)) - 32768;
    ax   = (plan_state.axis > AXIS_Z) ? 2 : int'(plan_state.axis);
    tol  = int'(cur_tol);
    tgt  = (plan_state.side == SIDE_NEG) ? -int'(cur_one_g) : int'(cur_one_g);
    kind = $urandom_range(0, 99);
    if (kind < 80 && tol > 0) begin
      lo = clamp16(tgt - tol + 1);
      hi = clamp16(tgt + tol - 1);
      vals[ax] = lo + int'($urandom_range(0, hi - lo));
    end else if (kind < 90) begin
      // right at the tolerance edge, just inside or just outside
      case ($urandom_range(0, 3))
        0:       vals[ax] = clamp16(tgt + tol);
        1:       vals[ax] = clamp16(tgt - tol);
        2:       vals[ax] = clamp16(tgt + tol - 1);
        default: vals[ax] = clamp16(tgt - tol + 1);
      endcase
    end else if (kind < 93) begin
      vals[ax] = clamp16(-tgt);  // opposite face
    end
    queue_sample(vals[0], vals[1], vals[2], $urandom_range(0, 3999) == 0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (samples_to_send.size() != 0 || results_due.size() != 0 || sample_ch.valid)
      @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_ONE_G) cur_one_g = val;
    else cur_tol = val;
  endtask

  initial begin
    // register settings per phase; the first keeps the reset values
    int setting_one_g[NUM_SETTINGS];
    int setting_tol[NUM_SETTINGS];
    int setting_items[NUM_SETTINGS];

    setting_one_g = '{8192, 32767, 1, 0, 1, 100, 0};
    setting_tol   = '{819, 32767, 0, 300, 1, 32767, 0};
    setting_items = '{300, 90, 90, 90, 90, 90, 90};
    setting_one_g[6] = $urandom_range(1, 32767);
    setting_tol[6]   = $urandom_range(1, 2000);

    sample_ch.valid   = 1'b0;
    sample_ch.accel_x = '0;
    sample_ch.accel_y = '0;
    sample_ch.accel_z = '0;
    sample_ch.restart = 1'b0;
    result_ch.ready   = 1'b0;
    clear_calib(plan_state);
    clear_calib(checked_state);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: tolerance edges at reset values, field extremes, restarts
    queue_sample(8192, 0, 0, 1'b0);                 // exactly one g
    queue_sample(8192 + 818, 0, 0, 1'b0);           // just inside
    queue_sample(8192 + 819, 0, 0, 1'b0);           // on the edge, rejected
    queue_sample(8192 - 818, 0, 0, 1'b0);
    queue_sample(8192 - 819, 0, 0, 1'b0);
    queue_sample(-8192, 8192, 8192, 1'b0);          // wrong face
    queue_sample(32767, 32767, 32767, 1'b0);
    queue_sample(-32768, -32768, -32768, 1'b0);
    queue_sample(21845, -21846, 21845, 1'b0);       // alternating bits
    queue_sample(-21846, 21845, -21846, 1'b0);
    queue_sample(8200, -32768, 32767, 1'b1);        // restart, then accepted
    queue_sample(8100, 1, -1, 1'b0);
    queue_sample(0, 0, 0, 1'b1);                    // restart, then rejected
    queue_sample(8192, -32768, 32767, 1'b0);
    queue_sample(8191, 32767, -32768, 1'b0);

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      if (ph > 0) begin
        wait_idle();
        repeat (8) @(posedge clk);
        write_reg(REG_ONE_G, CFG_W'(setting_one_g[ph]));
        write_reg(REG_TOL, CFG_W'(setting_tol[ph]));
        @(negedge clk);
      end
      for (int n = 0; n < setting_items[ph]; n++) begin
        // sender pause: let everything drain before going on
        if (ph == 0 && n == 60) wait_idle();
        queue_random_sample();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (!failed)
      $display("accel_six_face_calibrator_core regression: pass");
    else
      $display("accel_six_face_calibrator_core regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
